// ===== src/lotune_pkg.sv =====
// ----------------------------------------------------------------------------
// lotune_pkg
// Shared types, codes and constants of the LO tuning block.
// ----------------------------------------------------------------------------
`default_nettype none

package lotune_pkg;

    // Default sizes of the synthesizer table and of the IF set
    localparam int LT_MAX_POINTS = 64;
    localparam int LT_MAX_IFS    = 8;

    // At most this many results per tune request
    localparam int LT_RESULT_LIMIT = 8;

    // Quotient bits of the rounding divider (power stays within +-328 dBm)
    localparam int LT_QUOT_W = 10;

    // Centi-dBm to dBm scale
    localparam int LT_CDB_SCALE = 100;

    // Item kinds carried in s_tuser
    localparam logic [1:0] OP_LOAD_POINT = 2'd0;
    localparam logic [1:0] OP_LOAD_IF    = 2'd1;
    localparam logic [1:0] OP_TUNE       = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_TUNED   = 2'd0;
    localparam logic [1:0] ST_KEPT    = 2'd1;
    localparam logic [1:0] ST_BELOW   = 2'd2;
    localparam logic [1:0] ST_ABOVE   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_LO_MIN     = 3'd0;
    localparam logic [2:0] REG_LO_MAX     = 3'd1;
    localparam logic [2:0] REG_SECOND_LO  = 3'd2;
    localparam logic [2:0] REG_POINTS     = 3'd3;
    localparam logic [2:0] REG_IFS        = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // take the input word
        logic decode;    // write tables, check range, start scan
        logic scan_run;  // read next point and compare previous one
        logic mul;       // form the two weighted products
        logic sum;       // add the products
        logic prep;      // set up the rounding divider
        logic div_step;  // one quotient bit
        logic finish;    // store power and LO
        logic emit;      // load one result word
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic op_tune;
        logic op_load;
        logic tune_ok;
        logic scan_done;
        logic div_done;
        logic out_free;
        logic last_if;
    } stat_t;

endpackage

`default_nettype wire

// ===== src/lotune_ctrl.sv =====
// ----------------------------------------------------------------------------
// lotune_ctrl
// Sequencer for load and tune words: scan, interpolate, divide, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module lotune_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire lotune_pkg::stat_t stat,
    output lotune_pkg::cmd_t       cmd
);
    import lotune_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SCAN, S_MUL, S_SUM, S_PREP, S_DIV, S_FINISH, S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_tvalid && s_tready_reg) state_next = S_DECODE;
            S_DECODE: begin
                if (!stat.op_tune)     state_next = S_IDLE;
                else if (stat.tune_ok) state_next = S_SCAN;
                else                   state_next = S_EMIT;
            end
            S_SCAN:   if (stat.scan_done) state_next = S_MUL;
            S_MUL:    state_next = S_SUM;
            S_SUM:    state_next = S_PREP;
            S_PREP:   state_next = S_DIV;
            S_DIV:    if (stat.div_done) state_next = S_FINISH;
            S_FINISH: state_next = S_EMIT;
            S_EMIT:   if (stat.out_free && stat.last_if) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd          = '0;
        cmd.capture  = (state_reg == S_IDLE) && s_tvalid && s_tready_reg;
        cmd.decode   = (state_reg == S_DECODE);
        cmd.scan_run = (state_reg == S_SCAN);
        cmd.mul      = (state_reg == S_MUL);
        cmd.sum      = (state_reg == S_SUM);
        cmd.prep     = (state_reg == S_PREP);
        cmd.div_step = (state_reg == S_DIV) && !stat.div_done;
        cmd.finish   = (state_reg == S_FINISH);
        cmd.emit     = (state_reg == S_EMIT) && stat.out_free;
    end

    // State and ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_tready = s_tready_reg;

`ifndef ASSERT_OFF
    // A word taken while idle leads to decode
    a_cap_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> state_reg == S_DECODE)
        else $error("capture did not lead to decode");
    // Ready only while idle
    a_rdy_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    // Scan completes before arithmetic
    a_scan_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |-> $past(stat.scan_done))
        else $error("multiply before scan done");
`endif

endmodule

`default_nettype wire

// ===== src/lotune_dp.sv =====
// ----------------------------------------------------------------------------
// lotune_dp
// Datapath: point memory, IF registers, scan, interpolation, divider, output.
// ----------------------------------------------------------------------------
`default_nettype none

module lotune_dp #(
    parameter int MAX_POINTS = lotune_pkg::LT_MAX_POINTS,
    parameter int MAX_IFS    = lotune_pkg::LT_MAX_IFS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lotune_pkg::cmd_t  cmd,
    output lotune_pkg::stat_t      stat,
    // item fields
    input  wire logic [1:0]        in_opcode,
    input  wire logic [5:0]        in_entry_index,
    input  wire logic [26:0]       in_point_freq_khz,
    input  wire logic signed [15:0] in_point_power_cdbm,
    input  wire logic [26:0]       in_if_start_khz,
    input  wire logic [26:0]       in_if_limit_khz,
    input  wire logic [26:0]       in_rf_top_khz,
    input  wire logic [26:0]       in_lo_request_khz,
    input  wire logic              in_keep_current,
    // configuration
    input  wire logic [26:0]       lo_min_khz,
    input  wire logic [26:0]       lo_max_khz,
    input  wire logic [26:0]       second_lo_khz,
    input  wire logic [6:0]        points_in_use,
    input  wire logic [3:0]        ifs_in_use,
    // result side
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic [1:0]             out_status,
    output logic signed [9:0]      out_power_dbm,
    output logic [27:0]            out_freq_khz,
    output logic [26:0]            out_lo_now_khz,
    output logic [2:0]             out_if_number,
    output logic signed [28:0]     out_bw_khz,
    output logic                   out_last
);
    import lotune_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = (MAX_IFS > 1) ? $clog2(MAX_IFS) : 1;
    localparam int KW = $clog2(LT_QUOT_W);

    // Captured item
    logic [1:0]         op_reg;
    logic [5:0]         idx_reg;
    logic [26:0]        pf_in_reg, ifs_in_reg, ifl_in_reg, rft_in_reg, req_reg;
    logic signed [15:0] pp_in_reg;
    logic               keep_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= in_opcode;
            idx_reg    <= in_entry_index;
            pf_in_reg  <= in_point_freq_khz;
            pp_in_reg  <= in_point_power_cdbm;
            ifs_in_reg <= in_if_start_khz;
            ifl_in_reg <= in_if_limit_khz;
            rft_in_reg <= in_rf_top_khz;
            req_reg    <= in_lo_request_khz;
            keep_reg   <= in_keep_current;
        end
    end

    // Range check of the request
    logic [1:0] status_now;
    always_comb begin
        priority if (keep_reg)              status_now = ST_KEPT;
        else if (req_reg < lo_min_khz)      status_now = ST_BELOW;
        else if (req_reg > lo_max_khz)      status_now = ST_ABOVE;
        else                                status_now = ST_TUNED;
    end

    // Effective counts
    logic [CW-1:0] n_eff;
    logic [3:0]    cnt_eff;
    always_comb begin
        if (points_in_use == 7'd0)                n_eff = CW'(1);
        else if (32'(points_in_use) > MAX_POINTS) n_eff = CW'(MAX_POINTS);
        else                                      n_eff = CW'(points_in_use);
        if (ifs_in_use == 4'd0)                   cnt_eff = 4'd1;
        else if (32'(ifs_in_use) > MAX_IFS)       cnt_eff = 4'(MAX_IFS);
        else                                      cnt_eff = ifs_in_use;
        if (32'(cnt_eff) > LT_RESULT_LIMIT)       cnt_eff = 4'(LT_RESULT_LIMIT);
    end

    logic wr_point, wr_if;
    assign wr_point = cmd.decode && (op_reg == OP_LOAD_POINT) && (32'(idx_reg) < MAX_POINTS);
    assign wr_if    = cmd.decode && (op_reg == OP_LOAD_IF) && (32'(idx_reg) < MAX_IFS);

    // Point memory, registered read
    logic [26:0]        pf_mem [MAX_POINTS];
    logic signed [15:0] pp_mem [MAX_POINTS];
    logic [26:0]        pf_rd_reg;
    logic signed [15:0] pp_rd_reg;
    logic [CW-1:0]      j_reg;
    logic               rd_v_reg;
    logic               issued_all;

    assign issued_all = (j_reg == n_eff);

    always_ff @(posedge aclk) begin
        if (wr_point) begin
            pf_mem[AW'(idx_reg)] <= pf_in_reg;
            pp_mem[AW'(idx_reg)] <= pp_in_reg;
        end
        if (cmd.scan_run && !issued_all) begin
            pf_rd_reg <= pf_mem[j_reg[AW-1:0]];
            pp_rd_reg <= pp_mem[j_reg[AW-1:0]];
        end
    end

    // Scan control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_reg    <= '0;
            rd_v_reg <= 1'b0;
        end else if (cmd.decode) begin
            j_reg    <= '0;
            rd_v_reg <= 1'b0;
        end else if (cmd.scan_run) begin
            rd_v_reg <= !issued_all;
            if (!issued_all) j_reg <= j_reg + CW'(1);
        end
    end

    // Synthesizer frequency and scan bracket
    logic [27:0]        x_reg;
    logic               match_reg, lo_v_reg, hi_v_reg;
    logic [26:0]        lo_f_reg, hi_f_reg;
    logic signed [15:0] match_p_reg, lo_p_reg, hi_p_reg;
    logic [27:0]        f_ext;

    assign f_ext = {1'b0, pf_rd_reg};

    always_ff @(posedge aclk) begin
        if (cmd.decode) begin
            x_reg     <= {1'b0, req_reg} + {1'b0, second_lo_khz};
            match_reg <= 1'b0;
            lo_v_reg  <= 1'b0;
            hi_v_reg  <= 1'b0;
        end else if (cmd.scan_run && rd_v_reg && !match_reg) begin
            priority if (x_reg == f_ext) begin
                match_reg   <= 1'b1;
                match_p_reg <= pp_rd_reg;
            end else if (x_reg < f_ext) begin
                if (!hi_v_reg || pf_rd_reg < hi_f_reg) begin
                    hi_v_reg <= 1'b1;
                    hi_f_reg <= pf_rd_reg;
                    hi_p_reg <= pp_rd_reg;
                end
            end else begin
                if (!lo_v_reg || pf_rd_reg > lo_f_reg) begin
                    lo_v_reg <= 1'b1;
                    lo_f_reg <= pf_rd_reg;
                    lo_p_reg <= pp_rd_reg;
                end
            end
        end
    end

    // Weighted products and denominator
    logic signed [44:0] prod_a_reg, prod_b_reg;
    logic [33:0]        den_reg;
    logic signed [28:0] d_hi, d_lo;
    logic [26:0]        span;

    assign d_hi = $signed({2'b00, hi_f_reg}) - $signed({1'b0, x_reg});
    assign d_lo = $signed({1'b0, x_reg}) - $signed({2'b00, lo_f_reg});
    assign span = hi_f_reg - lo_f_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            priority if (match_reg) begin
                prod_a_reg <= 45'(match_p_reg);
                prod_b_reg <= '0;
                den_reg    <= 34'(LT_CDB_SCALE);
            end else if (lo_v_reg && hi_v_reg) begin
                prod_a_reg <= lo_p_reg * d_hi;
                prod_b_reg <= hi_p_reg * d_lo;
                den_reg    <= 34'(span) * 34'(LT_CDB_SCALE);
            end else if (!hi_v_reg) begin
                prod_a_reg <= 45'(lo_p_reg);
                prod_b_reg <= '0;
                den_reg    <= 34'(LT_CDB_SCALE);
            end else begin
                prod_a_reg <= 45'(hi_p_reg);
                prod_b_reg <= '0;
                den_reg    <= 34'(LT_CDB_SCALE);
            end
        end
    end

    // Numerator, then divider setup for half-away-from-zero rounding
    logic signed [45:0] num_reg;
    logic [47:0]        rem_reg;
    logic [34:0]        dsor_reg;
    logic               neg_reg;
    logic [LT_QUOT_W-1:0] q_reg;
    logic [KW-1:0]      k_reg;
    logic               div_fin_reg;
    logic [45:0]        mag;
    logic [47:0]        trial;

    assign mag   = num_reg[45] ? 46'(-num_reg) : 46'(num_reg);
    assign trial = 48'(dsor_reg) << k_reg;

    always_ff @(posedge aclk) begin
        if (cmd.sum) num_reg <= 46'(prod_a_reg) + 46'(prod_b_reg);
        if (cmd.prep) begin
            rem_reg  <= {1'b0, mag, 1'b0} + 48'(den_reg);
            dsor_reg <= {den_reg, 1'b0};
            neg_reg  <= num_reg[45];
            q_reg    <= '0;
            k_reg    <= KW'(LT_QUOT_W - 1);
        end else if (cmd.div_step) begin
            if (rem_reg >= trial) begin
                rem_reg      <= rem_reg - trial;
                q_reg[k_reg] <= 1'b1;
            end
            if (k_reg != '0) k_reg <= k_reg - KW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)           div_fin_reg <= 1'b0;
        else if (cmd.prep)      div_fin_reg <= 1'b0;
        else if (cmd.div_step)  div_fin_reg <= (k_reg == '0);
    end

    // Per-item result fields and stored LO
    logic [1:0]         status_reg;
    logic signed [9:0]  power_reg;
    logic [27:0]        freq_reg;
    logic [26:0]        lo_reg;
    logic [3:0]         cnt_m1_reg;
    logic [IW-1:0]      i_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg <= '0;
        end else if (cmd.finish) begin
            lo_reg <= req_reg;
        end
        if (cmd.decode) begin
            status_reg <= status_now;
            power_reg  <= '0;
            freq_reg   <= (status_now == ST_TUNED) ?
                          ({1'b0, req_reg} + {1'b0, second_lo_khz}) : 28'd0;
            cnt_m1_reg <= cnt_eff - 4'd1;
            i_reg      <= '0;
        end else begin
            if (cmd.finish) power_reg <= neg_reg ? 10'(-q_reg) : 10'(q_reg);
            if (cmd.emit)   i_reg     <= i_reg + IW'(1);
        end
    end

    // IF registers
    logic [26:0]        if_start_reg [MAX_IFS];
    logic [26:0]        if_limit_reg [MAX_IFS];
    logic [26:0]        rf_top_reg   [MAX_IFS];
    logic signed [28:0] if_bw_reg    [MAX_IFS];
    logic [27:0]        edge_sum;
    logic signed [28:0] bw_raw, bw_lim, bw_now;

    assign edge_sum = {1'b0, if_start_reg[i_reg]} + {1'b0, lo_reg};
    assign bw_raw   = $signed({2'b00, rf_top_reg[i_reg]}) - $signed({1'b0, edge_sum});
    assign bw_lim   = $signed({2'b00, if_limit_reg[i_reg]});
    always_comb begin
        if (status_reg != ST_TUNED) bw_now = if_bw_reg[i_reg];
        else if (bw_raw > bw_lim)   bw_now = bw_lim;
        else                        bw_now = bw_raw;
    end

    always_ff @(posedge aclk) begin
        if (wr_if) begin
            if_start_reg[IW'(idx_reg)] <= ifs_in_reg;
            if_limit_reg[IW'(idx_reg)] <= ifl_in_reg;
            rf_top_reg[IW'(idx_reg)]   <= rft_in_reg;
            if_bw_reg[IW'(idx_reg)]    <= $signed({2'b00, ifl_in_reg});
        end else if (cmd.emit) begin
            if_bw_reg[i_reg] <= bw_now;
        end
    end

    // Output register
    logic               m_tvalid_reg;
    logic [1:0]         o_status_reg;
    logic signed [9:0]  o_power_reg;
    logic [27:0]        o_freq_reg;
    logic [26:0]        o_lo_reg;
    logic [2:0]         o_ifn_reg;
    logic signed [28:0] o_bw_reg;
    logic               o_last_reg;
    logic               last_now;

    assign last_now = (4'(i_reg) == cnt_m1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn)            m_tvalid_reg <= 1'b0;
        else if (cmd.emit)       m_tvalid_reg <= 1'b1;
        else if (m_tready)       m_tvalid_reg <= 1'b0;
        if (cmd.emit) begin
            o_status_reg <= status_reg;
            o_power_reg  <= power_reg;
            o_freq_reg   <= freq_reg;
            o_lo_reg     <= lo_reg;
            o_ifn_reg    <= 3'(i_reg);
            o_bw_reg     <= bw_now;
            o_last_reg   <= last_now;
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign out_status     = o_status_reg;
    assign out_power_dbm  = o_power_reg;
    assign out_freq_khz   = o_freq_reg;
    assign out_lo_now_khz = o_lo_reg;
    assign out_if_number  = o_ifn_reg;
    assign out_bw_khz     = o_bw_reg;
    assign out_last       = o_last_reg;

    // Status to the controller
    always_comb begin
        stat.op_tune   = (op_reg == OP_TUNE);
        stat.op_load   = (op_reg == OP_LOAD_POINT) || (op_reg == OP_LOAD_IF);
        stat.tune_ok   = (status_now == ST_TUNED);
        stat.scan_done = issued_all && !rd_v_reg;
        stat.div_done  = div_fin_reg;
        stat.out_free  = !m_tvalid_reg || m_tready;
        stat.last_if   = last_now;
    end

`ifndef ASSERT_OFF
    // Never overwrite an unaccepted result
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result overwritten");
    // Divider finishes only after the last quotient bit
    a_div_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(div_fin_reg) |-> $past(cmd.div_step) && k_reg == '0)
        else $error("divider ended early");
    // Untuned results carry no power and no frequency
    a_untuned: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_status != ST_TUNED) |-> (out_power_dbm == '0 && out_freq_khz == '0))
        else $error("untuned result carries power or frequency");
`endif

endmodule

`default_nettype wire

// ===== src/lo_tuning_with_table_interpolation.sv =====
// ----------------------------------------------------------------------------
// lo_tuning_with_table_interpolation
// Receiver LO tuning with a piecewise-linear synthesizer power table.
// ----------------------------------------------------------------------------
// Load words (table point or IF entry) are written in the decode state. In a
// tune word the table points in use are read from the table memory one per
// cycle, the rounded power comes from a ten-step restoring divider, and the
// results leave one per cycle through an output register as the sink takes
// them. A tune word that is kept or out of range skips the scan and divide.
// The block takes the next word once the last result of a tune is loaded.
`default_nettype none

module lo_tuning_with_table_interpolation #(
    parameter int MAX_POINTS = lotune_pkg::LT_MAX_POINTS,
    parameter int MAX_IFS    = lotune_pkg::LT_MAX_IFS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input words
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // entry_index[5:0], point_freq_khz[32:6], point_power_cdbm[48:33],
    // if_start_khz[75:49], if_limit_khz[102:76], rf_top_khz[129:103],
    // lo_request_khz[156:130], keep_current[157]
    input  wire logic [159:0] s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]   s_tuser,
    // result words
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // synth_power_dbm[9:0], synth_freq_khz[37:10], lo_now_khz[64:38],
    // if_number[67:65], if_bandwidth_khz[96:68]
    output logic [103:0]      m_tdata,
    // status[1:0]
    output logic [1:0]        m_tuser,
    output logic              m_tlast,
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import lotune_pkg::*;

    // Configuration registers
    logic [26:0] lo_min_reg, lo_max_reg, second_lo_reg;
    logic [6:0]  points_reg;
    logic [3:0]  ifs_reg;
    logic [2:0]  reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_min_reg    <= '0;
            lo_max_reg    <= 27'd100000000;
            second_lo_reg <= '0;
            points_reg    <= 7'd1;
            ifs_reg       <= 4'd1;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_LO_MIN:    lo_min_reg    <= pwdata[26:0];
                REG_LO_MAX:    lo_max_reg    <= pwdata[26:0];
                REG_SECOND_LO: second_lo_reg <= pwdata[26:0];
                REG_POINTS:    points_reg    <= pwdata[6:0];
                REG_IFS:       ifs_reg       <= pwdata[3:0];
                default:       ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_LO_MIN:    prdata = {5'd0, lo_min_reg};
            REG_LO_MAX:    prdata = {5'd0, lo_max_reg};
            REG_SECOND_LO: prdata = {5'd0, second_lo_reg};
            REG_POINTS:    prdata = {25'd0, points_reg};
            REG_IFS:       prdata = {28'd0, ifs_reg};
            default:       prdata = '0;
        endcase
    end

    cmd_t  cmd;
    stat_t stat;

    logic [1:0]         o_status;
    logic signed [9:0]  o_power;
    logic [27:0]        o_freq;
    logic [26:0]        o_lo;
    logic [2:0]         o_ifn;
    logic signed [28:0] o_bw;

    lotune_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lotune_dp #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_IFS    (MAX_IFS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .in_opcode           (s_tuser),
        .in_entry_index      (s_tdata[5:0]),
        .in_point_freq_khz   (s_tdata[32:6]),
        .in_point_power_cdbm (s_tdata[48:33]),
        .in_if_start_khz     (s_tdata[75:49]),
        .in_if_limit_khz     (s_tdata[102:76]),
        .in_rf_top_khz       (s_tdata[129:103]),
        .in_lo_request_khz   (s_tdata[156:130]),
        .in_keep_current     (s_tdata[157]),
        .lo_min_khz          (lo_min_reg),
        .lo_max_khz          (lo_max_reg),
        .second_lo_khz       (second_lo_reg),
        .points_in_use       (points_reg),
        .ifs_in_use          (ifs_reg),
        .m_tready            (m_tready),
        .m_tvalid            (m_tvalid),
        .out_status          (o_status),
        .out_power_dbm       (o_power),
        .out_freq_khz        (o_freq),
        .out_lo_now_khz      (o_lo),
        .out_if_number       (o_ifn),
        .out_bw_khz          (o_bw),
        .out_last            (m_tlast)
    );

    // Pack the result word
    assign m_tdata = {7'd0, o_bw, o_ifn, o_lo, o_freq, o_power};
    assign m_tuser = o_status;

endmodule

`default_nettype wire
